// ===== rtl/core/sudt_pkg.sv =====
package sudt_pkg;

	localparam int QUEUES_DEF = 8;
	localparam int DEPTH_DEF  = 16;

	localparam logic [1:0] OP_INCLUDE = 2'd0;
	localparam logic [1:0] OP_QUERY   = 2'd1;
	localparam logic [1:0] OP_DOUBLE  = 2'd2;

	localparam logic [31:0] CAP_INIT = 32'h0000_0001;
	localparam logic [31:0] CAP_HALF = 32'h4000_0000;
	localparam logic [31:0] CAP_MAX  = 32'h8000_0000;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  queue;
		logic [31:0] delay_value;
		logic [3:0]  slot;
	} sudt_item_t;

	typedef struct packed {
		logic [4:0]  count;
		logic [31:0] slot_delay;
		logic [3:0]  position;
		logic [31:0] event_capacity;
		logic        already_present;
		logic        table_full;
	} sudt_res_t;

endpackage

// ===== rtl/core/sudt_in_if.sv =====
interface sudt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [2:0]  queue;
	logic [31:0] delay_value;
	logic [3:0]  slot;

	modport source (output valid, output op, output queue, output delay_value, output slot,
		input ready);
	modport sink (input valid, input op, input queue, input delay_value, input slot,
		output ready);
endinterface

// ===== rtl/core/sudt_out_if.sv =====
interface sudt_out_if;
	logic        valid;
	logic        ready;
	logic [4:0]  count;
	logic [31:0] slot_delay;
	logic [3:0]  position;
	logic [31:0] event_capacity;
	logic        already_present;
	logic        table_full;

	modport source (output valid, output count, output slot_delay, output position,
		output event_capacity, output already_present, output table_full, input ready);
	modport sink (input valid, input count, input slot_delay, input position,
		input event_capacity, input already_present, input table_full, output ready);
endinterface

// ===== rtl/core/sudt_ram.sv =====
module sudt_ram #(
	parameter int WIDTH = 32,
	parameter int WORDS = 16,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/sudt_engine.sv =====
module sudt_engine #(
	parameter int QUEUES = sudt_pkg::QUEUES_DEF,
	parameter int DEPTH  = sudt_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sudt_pkg::sudt_item_t item,
	output logic                ready,
	output logic                done,
	output sudt_pkg::sudt_res_t  res,
	input  logic                take
);

	import sudt_pkg::*;

	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int SW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(QUEUES * DEPTH);

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CNT   = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_EVAL  = 4'd4;
	localparam logic [3:0] ST_SHIFT = 4'd5;
	localparam logic [3:0] ST_INS   = 4'd6;
	localparam logic [3:0] ST_CAP   = 4'd7;
	localparam logic [3:0] ST_QRY   = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	function automatic logic [QW-1:0] qmod(input logic [2:0] v);
		logic [6:0] r;
		r = 7'(v);
		for (int k = 0; k < 8; k++) begin
			if (r >= 7'(QUEUES)) begin
				r = r - 7'(QUEUES);
			end
		end
		return QW'(r);
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [QW-1:0] qi, input logic [SW-1:0] si);
		return AW'(32'(qi) * 32'(DEPTH) + 32'(si));
	endfunction

	logic [3:0]    state_q, state_d;
	logic [QW-1:0] cq_q;
	logic [SW-1:0] cs_q;
	logic          clr_last;

	logic [1:0]    op_q;
	logic [QW-1:0] qi_q;
	logic [31:0]   dly_q;
	logic [3:0]    slot_q;
	logic [CW-1:0] n_q;
	logic [SW-1:0] idx_q;
	logic [CW-1:0] pos_q;
	logic          present_q;
	logic [CW-1:0] rem_q;
	logic [SW-1:0] sh_q;
	logic [SW-1:0] widx_q;
	logic          wpend_q;
	sudt_res_t     res_q;

	logic          cnt_we;
	logic [QW-1:0] cnt_waddr, cnt_raddr;
	logic [CW-1:0] cnt_wdata, cnt_rdata;
	logic          dly_we;
	logic [AW-1:0] dly_waddr, dly_raddr;
	logic [31:0]   dly_wdata, dly_rdata;
	logic          cap_we;
	logic [AW-1:0] cap_waddr, cap_raddr;
	logic [31:0]   cap_wdata, cap_rdata;

	logic [SW-1:0] sidx;
	logic          slot_oob;
	logic          list_full;
	logic          scan_hit;
	logic          scan_last;
	logic [31:0]   cap_dbl;
	logic [31:0]   cap_new;

	assign sidx      = SW'(slot_q);
	assign slot_oob  = 32'(slot_q) >= 32'(DEPTH);
	assign list_full = 32'(n_q) >= 32'(DEPTH);
	assign scan_hit  = dly_rdata >= dly_q;
	assign scan_last = (32'(idx_q) + 32'd1) == 32'(n_q);
	assign cap_dbl   = (cap_rdata >= CAP_HALF) ? CAP_MAX : {cap_rdata[30:0], 1'b0};
	assign cap_new   = (op_q == OP_DOUBLE) ? cap_dbl : cap_rdata;
	assign clr_last  = (cs_q == SW'(DEPTH - 1)) && (cq_q == QW'(QUEUES - 1));

	assign ready = state_q == ST_IDLE;
	assign done  = state_q == ST_DONE;
	assign res   = res_q;

	sudt_ram #(.WIDTH(CW), .WORDS(QUEUES)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	sudt_ram #(.WIDTH(32), .WORDS(QUEUES * DEPTH)) u_dly_ram (
		.clk(clk), .we(dly_we), .waddr(dly_waddr), .wdata(dly_wdata),
		.raddr(dly_raddr), .rdata(dly_rdata)
	);

	sudt_ram #(.WIDTH(32), .WORDS(QUEUES * DEPTH)) u_cap_ram (
		.clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
		.raddr(cap_raddr), .rdata(cap_rdata)
	);

	always_comb begin
		state_d   = state_q;
		cnt_we    = 1'b0;
		cnt_waddr = qi_q;
		cnt_wdata = CW'(n_q + 1'b1);
		cnt_raddr = qi_q;
		dly_we    = 1'b0;
		dly_waddr = addr_of(qi_q, SW'(pos_q));
		dly_wdata = dly_q;
		dly_raddr = addr_of(qi_q, SW'(idx_q + 1'b1));
		cap_we    = 1'b0;
		cap_waddr = addr_of(qi_q, sidx);
		cap_wdata = cap_dbl;
		cap_raddr = addr_of(qi_q, SW'(pos_q));
		case (state_q)
			ST_CLR: begin
				cap_we    = 1'b1;
				cap_waddr = addr_of(cq_q, cs_q);
				cap_wdata = CAP_INIT;
				cnt_we    = cs_q == '0;
				cnt_waddr = cq_q;
				cnt_wdata = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cnt_raddr = qmod(item.queue);
				if (start) begin
					state_d = ST_CNT;
				end
			end
			ST_CNT: begin
				if (op_q == OP_INCLUDE) begin
					if (cnt_rdata == '0) begin
						state_d = ST_EVAL;
					end else begin
						dly_raddr = addr_of(qi_q, '0);
						state_d   = ST_SCAN;
					end
				end else if (slot_oob) begin
					state_d = ST_DONE;
				end else begin
					dly_raddr = addr_of(qi_q, sidx);
					cap_raddr = addr_of(qi_q, sidx);
					state_d   = ST_QRY;
				end
			end
			ST_SCAN: begin
				if (scan_hit || scan_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (present_q) begin
					state_d = ST_CAP;
				end else if (list_full) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				dly_we    = wpend_q;
				dly_waddr = addr_of(qi_q, widx_q);
				dly_wdata = dly_rdata;
				dly_raddr = addr_of(qi_q, sh_q);
				if (rem_q == '0 && !wpend_q) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				dly_we  = 1'b1;
				cnt_we  = 1'b1;
				state_d = ST_CAP;
			end
			ST_CAP: begin
				state_d = ST_DONE;
			end
			ST_QRY: begin
				cap_we  = op_q == OP_DOUBLE;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cq_q    <= '0;
			cs_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				if (cs_q == SW'(DEPTH - 1)) begin
					cs_q <= '0;
					cq_q <= cq_q + 1'b1;
				end else begin
					cs_q <= cs_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					op_q   <= item.op;
					qi_q   <= qmod(item.queue);
					dly_q  <= item.delay_value;
					slot_q <= item.slot;
				end
			end
			ST_CNT: begin
				n_q       <= cnt_rdata;
				idx_q     <= '0;
				pos_q     <= '0;
				present_q <= 1'b0;
				if (op_q != OP_INCLUDE && slot_oob) begin
					res_q <= '{count: 5'(cnt_rdata), slot_delay: 32'd0, position: slot_q,
						event_capacity: CAP_INIT, already_present: 1'b0, table_full: 1'b0};
				end
			end
			ST_SCAN: begin
				idx_q <= idx_q + 1'b1;
				if (scan_hit) begin
					pos_q     <= CW'(idx_q);
					present_q <= dly_rdata == dly_q;
				end else if (scan_last) begin
					pos_q <= n_q;
				end
			end
			ST_EVAL: begin
				rem_q   <= n_q - pos_q;
				sh_q    <= SW'(n_q - 1'b1);
				wpend_q <= 1'b0;
				if (!present_q && list_full) begin
					res_q <= '{count: 5'(n_q), slot_delay: dly_q, position: 4'd0,
						event_capacity: CAP_INIT, already_present: 1'b0, table_full: 1'b1};
				end
			end
			ST_SHIFT: begin
				if (rem_q != '0) begin
					wpend_q <= 1'b1;
					widx_q  <= sh_q + 1'b1;
					sh_q    <= sh_q - 1'b1;
					rem_q   <= rem_q - 1'b1;
				end else begin
					wpend_q <= 1'b0;
				end
			end
			ST_INS: begin
				n_q <= n_q + 1'b1;
			end
			ST_CAP: begin
				res_q <= '{count: 5'(n_q), slot_delay: dly_q, position: 4'(pos_q),
					event_capacity: cap_rdata, already_present: present_q, table_full: 1'b0};
			end
			ST_QRY: begin
				res_q <= '{count: 5'(n_q),
					slot_delay: (32'(slot_q) < 32'(n_q)) ? dly_rdata : 32'd0,
					position: slot_q, event_capacity: cap_new,
					already_present: 1'b0, table_full: 1'b0};
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/sorted_unique_delay_table.sv =====
// Channel  Direction  Payload
// req      in         op, queue, delay_value, slot
// rsp      out        count, slot_delay, position, event_capacity, already_present, table_full
//
// One transaction is worked on at a time; req.ready is high only while the sequencer is idle.
// A query or double reads the slot's delay and capacity and registers the result; an
// include scans the queue up to the slot of insertion, and the shift then walks the
// entries above it through the one read port.
// After reset a clearing pass over all QUEUES*DEPTH slots (128 by default) sets every capacity to one.
// The output register lets the next transaction be accepted while a result waits on rsp.ready.
module sorted_unique_delay_table #(
	parameter int QUEUES = sudt_pkg::QUEUES_DEF,
	parameter int DEPTH  = sudt_pkg::DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sudt_in_if.sink     req,
	sudt_out_if.source  rsp
);

	import sudt_pkg::*;

	sudt_item_t item;
	sudt_res_t  eng_res;
	sudt_res_t  out_q;
	logic       out_valid_q;
	logic       eng_ready;
	logic       eng_done;
	logic       start;
	logic       take;

	assign item      = '{op: req.op, queue: req.queue, delay_value: req.delay_value,
		slot: req.slot};
	assign req.ready = eng_ready;
	assign start     = req.valid && eng_ready;
	assign take      = eng_done && (!out_valid_q || rsp.ready);

	sudt_engine #(.QUEUES(QUEUES), .DEPTH(DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .ready(eng_ready),
		.done(eng_done), .res(eng_res), .take(take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= eng_res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.count           = out_q.count;
	assign rsp.slot_delay      = out_q.slot_delay;
	assign rsp.position        = out_q.position;
	assign rsp.event_capacity  = out_q.event_capacity;
	assign rsp.already_present = out_q.already_present;
	assign rsp.table_full      = out_q.table_full;

endmodule

// ===== rtl/core/sudt_checker.sv =====
module sudt_checker #(
	parameter int DEPTH = sudt_pkg::DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [4:0]  rsp_count,
	input logic [31:0] rsp_capacity,
	input logic        rsp_present,
	input logic        rsp_full
);

	import sudt_pkg::*;

	// A stalled result must stay on the port unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_capacity))
		else $error("result changed while stalled");

	// Only one transaction is in progress at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input accepted while busy");

	// Capacities start at one and are only ever doubled.
	a_cap_power: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot(rsp_capacity))
		else $error("capacity is not a power of two");

	// A dropped include only happens on a full list and never coincides with a match.
	a_full_list: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_full |-> !rsp_present && rsp_count == 5'(DEPTH))
		else $error("table full reported on a list that is not full");

endmodule

bind sorted_unique_delay_table sudt_checker #(.DEPTH(DEPTH)) u_sudt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_count(rsp.count),
	.rsp_capacity(rsp.event_capacity),
	.rsp_present(rsp.already_present),
	.rsp_full(rsp.table_full)
);

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sudt_pkg::*;

	localparam int QUEUES = QUEUES_DEF;
	localparam int DEPTH = DEPTH_DEF;
	localparam logic [1:0] OP_QUERY_ALT = 2'd3;
	localparam int RANDOM_ITEMS = 1600;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	class delay_table_scoreboard;
		logic [31:0] delays[QUEUES][DEPTH];
		logic [31:0] capacity[QUEUES][DEPTH];
		int fill_level[QUEUES];
		sudt_res_t pending_results[$];
		int mismatches;
		int accepted;
		int checked;
		int inserted;
		int duplicates;
		int dropped;
		int doublings;
		int saturated;

		function new();
			for (int q = 0; q < QUEUES; q++) begin
				fill_level[q] = 0;
				for (int s = 0; s < DEPTH; s++) begin
					delays[q][s] = '0;
					capacity[q][s] = CAP_INIT;
				end
			end
		endfunction

		function sudt_res_t predict_result(sudt_item_t it);
			sudt_res_t r;
			int q;
			int n;
			int p;
			int s;
			q = int'(it.queue) % QUEUES;
			n = fill_level[q];
			s = it.slot;
			r = '0;
			r.count = 5'(n);
			if (it.op == OP_INCLUDE) begin
				for (int i = 0; i < n; i++) begin
					if (delays[q][i] == it.delay_value) begin
						r.slot_delay = it.delay_value;
						r.position = 4'(i);
						r.event_capacity = capacity[q][i];
						r.already_present = 1'b1;
						duplicates++;
						return r;
					end
				end
				if (n >= DEPTH) begin
					r.slot_delay = it.delay_value;
					r.position = 4'd0;
					r.event_capacity = CAP_INIT;
					r.table_full = 1'b1;
					dropped++;
					return r;
				end
				p = 0;
				while (p < n && delays[q][p] < it.delay_value)
					p++;
				for (int j = n; j > p; j--)
					delays[q][j] = delays[q][j - 1];
				delays[q][p] = it.delay_value;
				fill_level[q] = n + 1;
				r.count = 5'(n + 1);
				r.slot_delay = it.delay_value;
				r.position = 4'(p);
				r.event_capacity = capacity[q][p];
				inserted++;
				return r;
			end
			if (s >= DEPTH) begin
				r.position = 4'(s);
				r.event_capacity = CAP_INIT;
				return r;
			end
			if (it.op == OP_DOUBLE) begin
				doublings++;
				if (capacity[q][s] == CAP_MAX)
					saturated++;
				capacity[q][s] = (capacity[q][s] >= CAP_HALF) ? CAP_MAX : capacity[q][s] << 1;
			end
			r.slot_delay = (s < n) ? delays[q][s] : '0;
			r.position = 4'(s);
			r.event_capacity = capacity[q][s];
			return r;
		endfunction

		function void note_request(sudt_item_t it);
			accepted++;
			pending_results.push_back(predict_result(it));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
			end
		endfunction

		function void check_response(sudt_res_t got);
			sudt_res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with no transaction outstanding, expected none, actual %p",
					$time, got);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			compare_field("count", want.count, got.count);
			compare_field("slot_delay", want.slot_delay, got.slot_delay);
			compare_field("position", want.position, got.position);
			compare_field("event_capacity", want.event_capacity, got.event_capacity);
			compare_field("already_present", want.already_present, got.already_present);
			compare_field("table_full", want.table_full, got.table_full);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit calm;
	int cycles;
	delay_table_scoreboard sb;

	sudt_in_if req();
	sudt_out_if rsp();

	sorted_unique_delay_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic sudt_item_t make_item(logic [1:0] op, int q, logic [31:0] d, int s);
		sudt_item_t it;
		it.op = op;
		it.queue = 3'(q);
		it.delay_value = d;
		it.slot = 4'(s);
		return it;
	endfunction

	function automatic sudt_item_t random_request();
		sudt_item_t it;
		int pick;
		int kind;
		int n;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 99);
		it.queue = 3'($urandom_range(0, QUEUES - 1));
		it.slot = 4'($urandom_range(0, DEPTH - 1));
		it.delay_value = $urandom;
		if (pick < 40) begin
			it.op = OP_INCLUDE;
			n = sb.fill_level[it.queue];
			if (kind < 35 && n > 0) begin
				it.delay_value = sb.delays[it.queue][$urandom_range(0, n - 1)];
			end else if (kind < 50) begin
				case ($urandom_range(0, 3))
					0: it.delay_value = 32'h0000_0000;
					1: it.delay_value = 32'hFFFF_FFFF;
					2: it.delay_value = 32'h0000_0001;
					default: it.delay_value = 32'hFFFF_FFFE;
				endcase
			end else if (kind < 70) begin
				it.delay_value = $urandom_range(0, 63);
			end
		end else if (pick < 62) begin
			it.op = OP_QUERY;
		end else if (pick < 70) begin
			it.op = OP_QUERY_ALT;
		end else begin
			it.op = OP_DOUBLE;
			if (kind < 50) begin
				it.queue = 3'd0;
				it.slot = 4'($urandom_range(0, 1));
			end
		end
		return it;
	endfunction

	task automatic send_request(sudt_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= it.op;
		req.queue <= it.queue;
		req.delay_value <= it.delay_value;
		req.slot <= it.slot;
		do @(posedge clk); while (!req.ready);
		sb.note_request(it);
	endtask

	initial begin
		sudt_res_t got;
		int stall;
		rsp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			got.count = rsp.count;
			got.slot_delay = rsp.slot_delay;
			got.position = rsp.position;
			got.event_capacity = rsp.event_capacity;
			got.already_present = rsp.already_present;
			got.table_full = rsp.table_full;
			sb.check_response(got);
		end
	end

	initial begin
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("tb_top failed");
		$finish;
	end

	initial begin
		sb = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.op <= OP_INCLUDE;
		req.queue <= '0;
		req.delay_value <= '0;
		req.slot <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Fill one queue in descending order so that every insertion shifts the whole list.
		for (int k = 0; k < DEPTH - 1; k++)
			send_request(make_item(OP_INCLUDE, 3, 32'hFFFF_FFFF - k * 32'h1111_1111, 0));
		send_request(make_item(OP_INCLUDE, 3, 32'h0000_0000, 0));
		send_request(make_item(OP_INCLUDE, 3, 32'h1234_5678, 0));
		send_request(make_item(OP_INCLUDE, 3, 32'h8888_8888, 0));
		send_request(make_item(OP_QUERY, 3, 32'hFFFF_FFFF, 0));
		send_request(make_item(OP_QUERY_ALT, 3, '0, 15));
		send_request(make_item(OP_QUERY, 5, '0, 15));
		send_request(make_item(OP_DOUBLE, 5, '0, 15));
		send_request(make_item(OP_DOUBLE, 3, '0, 0));
		send_request(make_item(OP_INCLUDE, 0, 32'hA5A5_5A5A, 7));

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			calm = ((k / 200) % 3) == 2;
			send_request(random_request());
		end
		req.valid <= 1'b0;
		calm = 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions and checked %0d results:", sb.accepted, sb.checked);
		$display("%0d inserted, %0d duplicates, %0d dropped.",
			sb.inserted, sb.duplicates, sb.dropped);
		$display("Capacity was doubled %0d times, %0d of them already at saturation.",
			sb.doublings, sb.saturated);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/sudt_pkg.sv
rtl/core/sudt_in_if.sv
rtl/core/sudt_out_if.sv
rtl/core/sudt_ram.sv
rtl/core/sudt_engine.sv
rtl/core/sorted_unique_delay_table.sv
rtl/core/sudt_checker.sv
verif/tb_top.sv
